### rtl/window_median_filter_macros.svh
// Assertion macros shared by the checker of the window median filter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define WMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("window median filter check failed");

// The consequent must hold in the same cycle as the antecedent.
`define WMF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window median filter check failed");

`endif

### rtl/wmf_pkg.sv
// Shared opcodes and the control word that the sequencer sends to each cell.
// No dependencies.
package wmf_pkg;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // store: sample chain moves one cell along
    logic load;   // report start: copy sample into the rotating slot, clear counts
    logic step;   // counting: compare, then rotate one cell along the ring
  } wmf_ctl_t;

endpackage

### rtl/wmf_cell.sv
// One cell of the median chain: a window sample, a rotating copy and rank counts.
// Depends on wmf_pkg.
module wmf_cell #(
  parameter int SAMPLE_BITS = 10,
  parameter int CNT_BITS    = 5,
  parameter int KLO         = 14,
  parameter int KHI         = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wmf_pkg::wmf_ctl_t      ctl,
  input  logic [SAMPLE_BITS-1:0] fix_in,
  input  logic [SAMPLE_BITS-1:0] rot_in,
  output logic [SAMPLE_BITS-1:0] fix_out,
  output logic [SAMPLE_BITS-1:0] rot_out,
  output logic [SAMPLE_BITS-1:0] lo_pick,
  output logic [SAMPLE_BITS-1:0] hi_pick
);

  logic [SAMPLE_BITS-1:0] fix_r, fix_nxt;
  logic [SAMPLE_BITS-1:0] rot_r, rot_nxt;
  logic [CNT_BITS-1:0]    lt_r, lt_nxt;
  logic [CNT_BITS-1:0]    eq_r, eq_nxt;
  logic [CNT_BITS:0]      top_rank;
  logic                   lo_hit;
  logic                   hi_hit;

  always_comb begin
    fix_nxt = fix_r;
    rot_nxt = rot_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.shift) begin
      fix_nxt = fix_in;
    end
    if (ctl.load) begin
      rot_nxt = fix_r;
      lt_nxt  = '0;
      eq_nxt  = '0;
    end else if (ctl.step) begin
      rot_nxt = rot_in;
      if (rot_r < fix_r) begin
        lt_nxt = lt_r + CNT_BITS'(1);
      end
      if (rot_r == fix_r) begin
        eq_nxt = eq_r + CNT_BITS'(1);
      end
    end
  end

  // The sample occupies sorted positions lt .. lt+eq-1; equal samples all
  // match the same position, so OR-ing the picks across cells is safe.
  assign top_rank = {1'b0, lt_r} + {1'b0, eq_r};
  assign lo_hit   = ({1'b0, lt_r} <= (CNT_BITS+1)'(KLO)) && (top_rank > (CNT_BITS+1)'(KLO));
  assign hi_hit   = ({1'b0, lt_r} <= (CNT_BITS+1)'(KHI)) && (top_rank > (CNT_BITS+1)'(KHI));
  assign lo_pick  = lo_hit ? fix_r : '0;
  assign hi_pick  = hi_hit ? fix_r : '0;
  assign fix_out  = fix_r;
  assign rot_out  = rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r <= '0;
    end else begin
      fix_r <= fix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

endmodule

### rtl/window_median_filter.sv
// Top level of the sliding-window median filter: sequencer, cell chain, result word.
// Depends on wmf_pkg and wmf_cell.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid, in_stall | in_opcode, in_sample
//   out_    | output    | out_valid, out_stall | out_median
//
// A store word only moves the sample chain. A report word loads the rotating
// copies, makes WINDOW counting steps around the cell ring, gathers the two
// middle samples and then forms the result word.
// Reset (rst_n low at a clock edge) clears all window samples to zero and
// returns the sequencer to idle; early reports therefore count those zeros.
// A pending result word holds while out_stall is high; stores are still taken
// then, and a report finishes its counting but waits before writing its result.
module window_median_filter #(
  parameter int WINDOW      = 30,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_median
);

  // Rank counts must hold the full window size; the step counter only
  // needs to count WINDOW steps starting from zero.
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int STEP_BITS = $clog2(WINDOW);
  // Sorted positions of the lower and upper middle sample; equal for odd windows.
  localparam int KLO = (WINDOW - 1) / 2;
  localparam int KHI = WINDOW / 2;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COUNT  = 2'd1;
  localparam logic [1:0] ST_PICK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_median_r, out_median_nxt;
  logic [SAMPLE_BITS-1:0] lo_r, lo_nxt;
  logic [SAMPLE_BITS-1:0] hi_r, hi_nxt;
  logic [SAMPLE_BITS:0]   mid_sum;
  logic                   in_take;
  logic                   out_free;
  wmf_pkg::wmf_ctl_t      ctl;

  logic [SAMPLE_BITS-1:0] fix_q   [WINDOW];
  logic [SAMPLE_BITS-1:0] rot_q   [WINDOW];
  logic [SAMPLE_BITS-1:0] lo_pick [WINDOW];
  logic [SAMPLE_BITS-1:0] hi_pick [WINDOW];

  // Words are taken only while idle; a report owns the chain until its
  // result is written.
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // The result register can be written when empty or when its word leaves now.
  assign out_free = !out_valid_r || !out_stall;

  assign ctl.shift = in_take && (in_opcode == wmf_pkg::OP_STORE);
  assign ctl.load  = in_take && (in_opcode == wmf_pkg::OP_REPORT);
  assign ctl.step  = (state_r == ST_COUNT);

  // The cell chain. Samples move from cell 0 upward on a store, so the chain
  // holds the last WINDOW samples (the order of a multiset does not matter
  // for the median). The rotating copies form a closed ring, so after WINDOW
  // steps every cell has compared its sample with every sample, itself included.
  for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
    logic [SAMPLE_BITS-1:0] fix_from;
    logic [SAMPLE_BITS-1:0] rot_from;

    if (gi == 0) begin : g_head
      assign fix_from = in_sample;
      assign rot_from = rot_q[WINDOW-1];
    end else begin : g_body
      assign fix_from = fix_q[gi-1];
      assign rot_from = rot_q[gi-1];
    end

    wmf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_BITS   (CNT_BITS),
      .KLO        (KLO),
      .KHI        (KHI)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .fix_in (fix_from),
      .rot_in (rot_from),
      .fix_out(fix_q[gi]),
      .rot_out(rot_q[gi]),
      .lo_pick(lo_pick[gi]),
      .hi_pick(hi_pick[gi])
    );
  end

  // Every matching cell carries the same value, so a plain OR gathers it.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (state_r == ST_PICK) begin
      lo_nxt = '0;
      hi_nxt = '0;
      for (int i = 0; i < WINDOW; i++) begin
        lo_nxt = lo_nxt | lo_pick[i];
        hi_nxt = hi_nxt | hi_pick[i];
      end
    end
  end

  // Floor of the mean of the two middle samples; for an odd window both
  // are the same sample and this returns it unchanged.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (ctl.load) begin
          state_nxt = ST_COUNT;
          step_nxt  = '0;
        end
      end
      ST_COUNT: begin
        step_nxt = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(WINDOW - 1)) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_median_nxt = mid_sum[SAMPLE_BITS:1];
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    out_median_r <= out_median_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

### rtl/wmf_checker.sv
// Port-level checks for the window median filter, bound to its top level.
// Depends on wmf_pkg and window_median_filter_macros.svh.
`include "window_median_filter_macros.svh"

module wmf_checker #(
  parameter int SAMPLE_BITS = 10
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   in_opcode,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_median
);

  logic store_take;
  logic report_take;

  assign store_take  = in_valid && !in_stall && (in_opcode == wmf_pkg::OP_STORE);
  assign report_take = in_valid && !in_stall && (in_opcode == wmf_pkg::OP_REPORT);

  // A result word waiting on a stall stays put.
  `WMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_median))
  // A report occupies the block: the next word is held off.
  `WMF_ASSERT_NEXT(a_report_busy, report_take, in_stall)
  // A store never produces a result word.
  `WMF_ASSERT_NEXT(a_store_silent, store_take && !out_valid, !out_valid)
  // A result word appears exactly as the block goes back to taking words.
  `WMF_ASSERT_SAME(a_result_idle, $rose(out_valid), !in_stall)

endmodule

bind window_median_filter wmf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_opcode (in_opcode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_median(out_median)
);

### test/window_median_filter_checker.sv
// Self-checking monitor for the window median filter: predicts each median and compares it.
// Depends on wmf_pkg for the opcode names; watches the block's ports only.
module window_median_filter_checker #(
  parameter int WINDOW      = 30,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_opcode,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [SAMPLE_BITS-1:0] out_median,
  output int                     mismatch_count,
  output int                     medians_pending,
  output int                     medians_checked
);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  sample_t     sample_ring [WINDOW];
  int unsigned ring_wr_pos;
  sample_t     median_fifo [$];
  int          n_mismatch = 0;
  int          n_checked  = 0;

  // Value at a given ascending rank: the entry that has at most rank entries
  // strictly below it and more than rank entries at or below it.
  function automatic sample_t ranked_sample(int unsigned rank);
    int unsigned below;
    int unsigned upto;
    ranked_sample = '0;
    for (int i = 0; i < WINDOW; i++) begin
      below = 0;
      upto  = 0;
      for (int j = 0; j < WINDOW; j++) begin
        if (sample_ring[j] < sample_ring[i]) below++;
        if (sample_ring[j] <= sample_ring[i]) upto++;
      end
      if (below <= rank && rank < upto) ranked_sample = sample_ring[i];
    end
  endfunction

  function automatic sample_t window_median();
    logic [SAMPLE_BITS:0] pair_sum;
    if (WINDOW % 2 == 1) return ranked_sample((WINDOW - 1) / 2);
    pair_sum = ranked_sample(WINDOW / 2 - 1) + ranked_sample(WINDOW / 2);
    return pair_sum[SAMPLE_BITS:1];
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      foreach (sample_ring[i]) sample_ring[i] = '0;
      ring_wr_pos = 0;
      median_fifo.delete();
    end else begin
      // Results first: a report taken at this edge cannot answer at this edge.
      if (out_valid && !out_stall) begin
        if (median_fifo.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: median word %0d arrived with none expected", out_median);
        end else begin
          want = median_fifo.pop_front();
          if (out_median !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: median expected %0d, got %0d", want, out_median);
          end else begin
            n_checked++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == wmf_pkg::OP_STORE) begin
          sample_ring[ring_wr_pos] = in_sample;
          ring_wr_pos = (ring_wr_pos == WINDOW - 1) ? 0 : ring_wr_pos + 1;
        end else begin
          median_fifo.push_back(window_median());
        end
      end
    end
    mismatch_count  <= n_mismatch;
    medians_pending <= median_fifo.size();
    medians_checked <= n_checked;
  end

endmodule

### test/window_median_filter_tb.sv
// Top of the window median filter testbench: clock, reset, stimulus, stall pattern, verdict.
// Depends on wmf_pkg, window_median_filter and window_median_filter_checker.
module window_median_filter_tb;

  localparam int WINDOW       = 30;
  localparam int SAMPLE_BITS  = 10;
  localparam int NUM_WORDS    = 550;
  // Idling stops for the final stretch of words so the tail runs at full rate.
  localparam int CALM_AT      = NUM_WORDS - 60;
  // Long hold-off on the result side, started once this many words went in.
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  // Slowest correct run is roughly 550 words times (report latency plus the
  // longest gap and stall) plus the hold-off; this is several times that.
  localparam int LIMIT_CYCLES = 200000;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Shapes of the sample runs that precede a report. Flat runs at either end
  // of the range drive the median to its extremes, and a split run of two
  // levels makes the two middle entries differ so the averaging is exercised.
  typedef enum int {
    FILL_SPREAD,
    FILL_CEILING,
    FILL_FLOOR,
    FILL_CLUSTER,
    FILL_SPLIT
  } fill_shape_t;

  logic    clk        = 1'b0;
  logic    rst_n      = 1'b0;
  logic    in_valid   = 1'b0;
  logic    in_stall;
  logic    in_opcode  = wmf_pkg::OP_STORE;
  sample_t in_sample  = '0;
  logic    out_valid;
  logic    out_stall  = 1'b0;
  sample_t out_median;

  int      mismatch_count;
  int      medians_pending;
  int      medians_checked;

  int      words_sent  = 0;
  int      stores_sent = 0;
  int      reports_sent = 0;
  int      cycle_count = 0;
  logic    hold_on     = 1'b0;
  int      stall_left  = 0;
  logic    calm;

  assign calm = (words_sent >= CALM_AT);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  window_median_filter #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_median (out_median)
  );

  window_median_filter_checker #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median),
    .mismatch_count  (mismatch_count),
    .medians_pending (medians_pending),
    .medians_checked (medians_checked)
  );

  // Offers one word and returns at the edge where it is taken. Before the word
  // the input side may go quiet for a short burst. Valid stays high and the
  // payload stays put for as long as the block stalls the word.
  task automatic send_word(input logic opcode, input sample_t sample);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= opcode;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (opcode == wmf_pkg::OP_STORE) stores_sent++;
    else reports_sent++;
  endtask

  // One sample of a run of the given shape; lo and hi are the run's levels
  // and idx its position, which alternates the levels of a split run.
  function automatic sample_t shaped_sample(fill_shape_t shape, sample_t lo, sample_t hi,
                                            int idx);
    int unsigned near;
    case (shape)
      FILL_CEILING: begin
        return SAMPLE_MAX;
      end
      FILL_FLOOR: begin
        return '0;
      end
      FILL_CLUSTER: begin
        near = lo + $urandom_range(0, 7);
        return (near > SAMPLE_MAX) ? SAMPLE_MAX : sample_t'(near);
      end
      FILL_SPLIT: begin
        return idx[0] ? hi : lo;
      end
      default: begin
        return sample_t'($urandom_range(0, SAMPLE_MAX));
      end
    endcase
  endfunction

  // Result side: short random stall bursts, none once the run is calm, and
  // one long hold-off (below) that backs the block up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_on) begin
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The hold-off is timed in cycles here, independent of the stimulus, which
  // keeps offering words so that a finished report waits and the input stalls.
  initial begin
    wait (words_sent >= HOLD_AT);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d medians still expected",
               cycle_count, medians_pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    fill_shape_t shape;
    int          run_len;
    sample_t     lo_level;
    sample_t     hi_level;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. A report straight after reset sees only the cleared
    // ring. A single large sample cannot move the median of a mostly zero
    // window. Alternating bit patterns and the edge values go in next, and two
    // reports back to back must agree since a report leaves the ring alone.
    send_word(wmf_pkg::OP_REPORT, sample_t'($urandom_range(0, SAMPLE_MAX)));
    send_word(wmf_pkg::OP_STORE, SAMPLE_MAX);
    send_word(wmf_pkg::OP_REPORT, '0);
    send_word(wmf_pkg::OP_STORE, '0);
    send_word(wmf_pkg::OP_STORE, sample_t'(10'h2AA));
    send_word(wmf_pkg::OP_STORE, sample_t'(10'h155));
    send_word(wmf_pkg::OP_REPORT, SAMPLE_MAX);
    send_word(wmf_pkg::OP_REPORT, sample_t'(10'h2AA));
    send_word(wmf_pkg::OP_STORE, sample_t'(1));
    send_word(wmf_pkg::OP_STORE, sample_t'(512));
    send_word(wmf_pkg::OP_STORE, SAMPLE_MAX - sample_t'(1));
    send_word(wmf_pkg::OP_REPORT, '0);
    send_word(wmf_pkg::OP_STORE, sample_t'(511));
    send_word(wmf_pkg::OP_STORE, SAMPLE_MAX);
    send_word(wmf_pkg::OP_REPORT, sample_t'(10'h155));

    // Random part. Most of it is runs of stores of one shape followed by one
    // to three reports; the rest is single words of either kind. Runs often
    // wrap the write position past the end of the ring.
    while (words_sent < NUM_WORDS) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word($urandom_range(0, 1) ? wmf_pkg::OP_REPORT : wmf_pkg::OP_STORE,
                  sample_t'($urandom_range(0, SAMPLE_MAX)));
      end else begin
        shape    = fill_shape_t'($urandom_range(0, 4));
        lo_level = sample_t'($urandom_range(0, SAMPLE_MAX));
        hi_level = sample_t'($urandom_range(0, SAMPLE_MAX));
        if (shape == FILL_CEILING || shape == FILL_FLOOR)
          run_len = $urandom_range(16, 35);
        else
          run_len = $urandom_range(1, 24);
        for (int k = 0; k < run_len; k++)
          send_word(wmf_pkg::OP_STORE, shaped_sample(shape, lo_level, hi_level, k));
        repeat ($urandom_range(1, 3))
          send_word(wmf_pkg::OP_REPORT, sample_t'($urandom_range(0, SAMPLE_MAX)));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected median, then give the block time to
    // show any stray result word.
    while (medians_pending != 0) @(posedge clk);
    repeat (2 * WINDOW + 10) @(posedge clk);

    $display("sent %0d stores and %0d reports; %0d medians matched, hold-off of %0d cycles",
             stores_sent, reports_sent, medians_checked, HOLD_CYCLES);
    if (mismatch_count == 0 && medians_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d medians never arrived", mismatch_count, medians_pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
